>>> rtl/core/chm_pkg.sv
// Shared types, constants and microcode ROM for the chained hash map engine.
package chm_pkg;

  localparam logic [31:0] HASH_MUL = 32'h9E37_79B1;

  localparam logic CMD_FIND    = 1'b0;
  localparam logic CMD_PUT     = 1'b1;
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_HEAD_RD,
    ST_HEAD_CHK,
    ST_WALK,
    ST_CMP,
    ST_HIT,
    ST_MISS
  } step_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CLEAR,
    ACT_LATCH,
    ACT_HASH,
    ACT_HEAD_RD,
    ACT_HEAD_LD,
    ACT_ENTRY_RD,
    ACT_LINK_LD,
    ACT_HIT,
    ACT_MISS
  } act_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_START,
    COND_CLR_DONE,
    COND_NO_ENTRY,
    COND_KEY_MATCH
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
    step_t seq;
  } ctrl_word_t;

  typedef struct packed {
    logic clr_done;
    logic no_entry;
    logic key_match;
  } flags_t;

  function automatic ctrl_word_t ucode_rom(input step_t step);
    ctrl_word_t w;
    unique case (step)
      ST_CLEAR:    w = '{ACT_CLEAR,    COND_CLR_DONE,  ST_IDLE,     ST_CLEAR};
      ST_IDLE:     w = '{ACT_LATCH,    COND_START,     ST_HASH,     ST_IDLE};
      ST_HASH:     w = '{ACT_HASH,     COND_ALWAYS,    ST_HEAD_RD,  ST_HEAD_RD};
      ST_HEAD_RD:  w = '{ACT_HEAD_RD,  COND_ALWAYS,    ST_HEAD_CHK, ST_HEAD_CHK};
      ST_HEAD_CHK: w = '{ACT_HEAD_LD,  COND_ALWAYS,    ST_WALK,     ST_WALK};
      ST_WALK:     w = '{ACT_ENTRY_RD, COND_NO_ENTRY,  ST_MISS,     ST_CMP};
      ST_CMP:      w = '{ACT_LINK_LD,  COND_KEY_MATCH, ST_HIT,      ST_WALK};
      ST_HIT:      w = '{ACT_HIT,      COND_ALWAYS,    ST_IDLE,     ST_IDLE};
      ST_MISS:     w = '{ACT_MISS,     COND_ALWAYS,    ST_IDLE,     ST_IDLE};
      default:     w = '{ACT_NONE,     COND_ALWAYS,    ST_IDLE,     ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/chm_useq.sv
// Microcode sequencer: step counter, control ROM and conditional branching.
module chm_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  chm_pkg::flags_t     flags,
  output chm_pkg::ctrl_word_t ctrl,
  output logic                busy
);
  import chm_pkg::*;

  step_t step_r;
  step_t step_nxt;
  ctrl_word_t word;
  logic take;

  assign word = ucode_rom(step_r);

  always_comb begin
    unique case (word.cond)
      COND_ALWAYS:    take = 1'b1;
      COND_START:     take = start;
      COND_CLR_DONE:  take = flags.clr_done;
      COND_NO_ENTRY:  take = flags.no_entry;
      COND_KEY_MATCH: take = flags.key_match;
      default:        take = 1'b0;
    endcase
    step_nxt = take ? word.target : word.seq;
  end

  always_comb begin
    ctrl = word;
    busy = (step_r != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_CLEAR;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

>>> rtl/core/chm_datapath.sv
// Datapath: hash, bucket head and entry stores, chain walk registers, result registers.
module chm_datapath #(
  parameter int BUCKET_BITS = 8,
  parameter int ENTRY_COUNT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  chm_pkg::ctrl_word_t ctrl,
  output chm_pkg::flags_t     flags,
  input  logic                in_command,
  input  logic [31:0]         in_key,
  input  logic [31:0]         in_value,
  output logic                out_valid,
  output logic                out_found,
  output logic [31:0]         out_read_value,
  output logic                out_status
);
  import chm_pkg::*;

  localparam int IDX_W = (ENTRY_COUNT > 2) ? $clog2(ENTRY_COUNT) : 1;
  localparam int CNT_W = $clog2(ENTRY_COUNT + 1);
  localparam int BKT_N = 1 << BUCKET_BITS;

  logic [IDX_W:0]       head_mem [BKT_N];
  logic [31:0]          key_mem  [ENTRY_COUNT];
  logic [31:0]          val_mem  [ENTRY_COUNT];
  logic [IDX_W:0]       link_mem [ENTRY_COUNT];

  logic                 cmd_r;
  logic [31:0]          key_r;
  logic [31:0]          val_r;
  logic [BUCKET_BITS-1:0] bucket_r;
  logic [BUCKET_BITS-1:0] clr_r;
  logic [IDX_W:0]       head_q;
  logic [IDX_W:0]       head_sv_r;
  logic [IDX_W-1:0]     cur_r;
  logic                 have_r;
  logic [31:0]          key_q;
  logic [31:0]          val_q;
  logic [IDX_W:0]       link_q;
  logic [CNT_W-1:0]     used_r;
  logic                 valid_r;
  logic                 found_r;
  logic [31:0]          rval_r;
  logic                 status_r;

  logic [31:0]          prod;
  logic                 full;
  logic                 key_match;
  logic [IDX_W-1:0]     fresh;
  logic                 new_ent;
  logic                 upd_val;
  logic                 head_we;
  logic [BUCKET_BITS-1:0] head_wa;
  logic [IDX_W:0]       head_wd;
  logic [IDX_W-1:0]     val_wa;

  assign prod      = key_r * HASH_MUL;
  assign full      = (used_r >= CNT_W'(ENTRY_COUNT));
  assign key_match = (key_q == key_r);
  assign fresh     = used_r[IDX_W-1:0];

  always_comb begin
    new_ent = (ctrl.act == ACT_MISS) && (cmd_r == CMD_PUT) && !full;
    upd_val = (ctrl.act == ACT_HIT) && (cmd_r == CMD_PUT);
    head_we = (ctrl.act == ACT_CLEAR) || new_ent;
    head_wa = (ctrl.act == ACT_CLEAR) ? clr_r : bucket_r;
    head_wd = (ctrl.act == ACT_CLEAR) ? '0 : {1'b1, fresh};
    val_wa  = new_ent ? fresh : cur_r;
    flags.clr_done  = (clr_r == {BUCKET_BITS{1'b1}});
    flags.no_entry  = !have_r;
    flags.key_match = key_match;
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (ctrl.act == ACT_HEAD_RD) begin
      head_q <= head_mem[bucket_r];
    end
  end

  always_ff @(posedge clk) begin
    if (new_ent) begin
      key_mem[fresh]  <= key_r;
      link_mem[fresh] <= head_sv_r;
    end
    if (new_ent || upd_val) begin
      val_mem[val_wa] <= val_r;
    end
    if (ctrl.act == ACT_ENTRY_RD) begin
      key_q  <= key_mem[cur_r];
      val_q  <= val_mem[cur_r];
      link_q <= link_mem[cur_r];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.act == ACT_LATCH) begin
      cmd_r <= in_command;
      key_r <= in_key;
      val_r <= in_value;
    end
    if (ctrl.act == ACT_HASH) begin
      bucket_r <= prod[31 -: BUCKET_BITS];
    end
    if (ctrl.act == ACT_HEAD_LD) begin
      head_sv_r <= head_q;
      cur_r     <= head_q[IDX_W-1:0];
    end else if ((ctrl.act == ACT_LINK_LD) && !key_match) begin
      cur_r <= link_q[IDX_W-1:0];
    end
    if (ctrl.act == ACT_HIT) begin
      found_r  <= 1'b1;
      rval_r   <= (cmd_r == CMD_PUT) ? 32'd0 : val_q;
      status_r <= STATUS_DONE;
    end else if (ctrl.act == ACT_MISS) begin
      found_r  <= 1'b0;
      rval_r   <= 32'd0;
      status_r <= ((cmd_r == CMD_PUT) && full) ? STATUS_FULL : STATUS_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      used_r  <= '0;
      have_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= (ctrl.act == ACT_HIT) || (ctrl.act == ACT_MISS);
      if (ctrl.act == ACT_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (new_ent) begin
        used_r <= used_r + 1'b1;
      end
      if (ctrl.act == ACT_HEAD_LD) begin
        have_r <= head_q[IDX_W];
      end else if ((ctrl.act == ACT_LINK_LD) && !key_match) begin
        have_r <= link_q[IDX_W];
      end
    end
  end

  assign out_valid      = valid_r;
  assign out_found      = found_r;
  assign out_read_value = rval_r;
  assign out_status     = status_r;

endmodule

>>> rtl/core/chained_hash_map_engine.sv
// Chained hash map engine: microcoded find/put over a separately chained table.
// Each request hashes the key and reads its bucket head, then walks the chain to a hit
// or to the chain's end (a miss); each chain entry costs one entry-store read.
// Throughput: one request at a time; the next is taken in the cycle out_valid is high.
// Reset: a clearing pass over all 2**BUCKET_BITS bucket heads empties them, busy high.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
module chained_hash_map_engine #(
  parameter int BUCKET_BITS = 8,
  parameter int ENTRY_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  output logic        out_valid,
  output logic        out_found,
  output logic [31:0] out_read_value,
  output logic        out_status
);
  import chm_pkg::*;

  ctrl_word_t ctrl;
  flags_t     flags;

  chm_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  chm_datapath #(
    .BUCKET_BITS (BUCKET_BITS),
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .flags          (flags),
    .in_command     (in_command),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_read_value (out_read_value),
    .out_status     (out_status)
  );

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the chained hash map engine against a map predictor.
module tb;
  import chm_pkg::*;

  localparam int ENTRY_COUNT = 256;
  localparam int IDLE_LIMIT = 4000;
  localparam int PRINT_LIMIT = 30;

  typedef struct packed {
    logic        found;
    logic [31:0] read_value;
    logic        status;
  } map_reply_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_command;
  logic [31:0] in_key;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_found;
  logic [31:0] out_read_value;
  logic        out_status;

  map_reply_t  pending_replies[$];
  logic [31:0] map_values[logic [31:0]];
  logic [31:0] stored_keys[$];
  int unsigned entries_taken = 0;
  int unsigned errors = 0;
  int unsigned printed = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_find = 0;
  int unsigned n_hit = 0;
  int unsigned n_put = 0;
  int unsigned n_overwrite = 0;
  int unsigned n_refused = 0;

  always #5 clk = ~clk;

  chained_hash_map_engine #(
    .BUCKET_BITS(8),
    .ENTRY_COUNT(ENTRY_COUNT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_key(in_key),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_found(out_found),
    .out_read_value(out_read_value),
    .out_status(out_status)
  );

  function automatic logic [7:0] bucket_index(input logic [31:0] key);
    logic [31:0] h;
    h = key * HASH_MUL;
    return h[31:24];
  endfunction

  function automatic logic [31:0] key_in_bucket(input logic [7:0] bucket);
    logic [31:0] k;
    k = $urandom;
    while (bucket_index(k) != bucket) k = $urandom;
    return k;
  endfunction

  function automatic logic [31:0] pick_stored_key();
    if (stored_keys.size() == 0) return $urandom;
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  function automatic map_reply_t predict_map_op(input logic cmd, input logic [31:0] key,
                                                input logic [31:0] value);
    map_reply_t r;
    r = '0;
    r.status = STATUS_DONE;
    r.found = (map_values.exists(key) != 0);
    if (cmd == CMD_FIND) begin
      n_find++;
      if (r.found) begin
        n_hit++;
        r.read_value = map_values[key];
      end
    end else begin
      n_put++;
      if (r.found) begin
        n_overwrite++;
        map_values[key] = value;
      end else if (entries_taken >= ENTRY_COUNT) begin
        n_refused++;
        r.status = STATUS_FULL;
      end else begin
        map_values[key] = value;
        stored_keys.push_back(key);
        entries_taken++;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (printed < PRINT_LIMIT) begin
      $display("tb: mismatch at %0t: %s, expected %h, got %h", $realtime, what, want, got);
      printed++;
    end
    errors++;
  endtask

  task automatic send_request(input logic cmd, input logic [31:0] key,
                              input logic [31:0] value);
    @(negedge clk);
    if (burst_left == 0) begin
      start = 1'b0;
      in_command = 1'($urandom);
      in_key = $urandom;
      in_value = $urandom;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
    end
    burst_left--;
    start = 1'b1;
    in_command = cmd;
    in_key = key;
    in_value = value;
    do @(posedge clk); while (busy);
    pending_replies.push_back(predict_map_op(cmd, key, value));
  endtask

  always @(posedge clk) begin
    map_reply_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with no request waiting", 32'h0, out_read_value);
      end else begin
        want = pending_replies.pop_front();
        if (out_found !== want.found)
          report_mismatch("found", 32'(want.found), 32'(out_found));
        if (out_read_value !== want.read_value)
          report_mismatch("read_value", want.read_value, out_read_value);
        if (out_status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(out_status));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_empty_finds();
    send_request(CMD_FIND, 32'h0000_0000, 32'h0000_0000);
    send_request(CMD_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_extreme_keys();
    send_request(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(CMD_FIND, 32'h0000_0000, 32'h0000_0000);
    send_request(CMD_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_PUT, 32'h0000_0000, 32'hA5A5_5A5A);
    send_request(CMD_FIND, 32'h0000_0000, $urandom);
  endtask

  task automatic test_shared_bucket();
    logic [7:0]  bucket;
    logic [31:0] chain_keys[4];
    bucket = 8'($urandom);
    foreach (chain_keys[i]) begin
      chain_keys[i] = key_in_bucket(bucket);
      send_request(CMD_PUT, chain_keys[i], $urandom);
    end
    send_request(CMD_FIND, chain_keys[0], $urandom);
    send_request(CMD_FIND, chain_keys[3], $urandom);
    send_request(CMD_FIND, chain_keys[1], $urandom);
    send_request(CMD_FIND, chain_keys[2], $urandom);
    send_request(CMD_FIND, key_in_bucket(bucket), $urandom);
    send_request(CMD_PUT, chain_keys[0], $urandom);
    send_request(CMD_FIND, chain_keys[0], $urandom);
  endtask

  task automatic test_random_mix(input int count);
    logic [7:0]  hot;
    logic [31:0] key;
    int          pick;
    hot = 8'($urandom);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) key = pick_stored_key();
      else if (pick < 70) key = key_in_bucket(hot);
      else key = $urandom;
      send_request(1'($urandom), key, $urandom);
    end
  endtask

  task automatic test_fill_pool();
    logic [7:0] hot;
    int         pick;
    hot = 8'($urandom);
    while (entries_taken < ENTRY_COUNT) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) send_request(CMD_PUT, key_in_bucket(hot), $urandom);
      else if (pick < 80) send_request(CMD_PUT, $urandom, $urandom);
      else if (pick < 90) send_request(CMD_FIND, pick_stored_key(), $urandom);
      else send_request(CMD_PUT, pick_stored_key(), $urandom);
    end
  endtask

  task automatic test_full_pool(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) send_request(CMD_PUT, $urandom, $urandom);
      else if (pick < 65) send_request(CMD_PUT, pick_stored_key(), $urandom);
      else if (pick < 85) send_request(CMD_FIND, pick_stored_key(), $urandom);
      else send_request(CMD_FIND, $urandom, $urandom);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_FIND;
    in_key = 32'h0;
    in_value = 32'h0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_finds();
    test_extreme_keys();
    test_shared_bucket();
    test_random_mix(150);
    test_fill_pool();
    test_full_pool(150);

    @(negedge clk);
    start = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("tb: %0d requests: %0d finds with %0d hits, %0d puts", n_find + n_put, n_find,
             n_hit, n_put);
    $display("tb: %0d of %0d pool entries taken, %0d overwrites, %0d puts refused when full",
             entries_taken, ENTRY_COUNT, n_overwrite, n_refused);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/chm_pkg.sv
rtl/core/chm_useq.sv
rtl/core/chm_datapath.sv
rtl/core/chained_hash_map_engine.sv
tb/sv/tb.sv
